// File: hdl/rsa_modexp_pkg.sv
// shared types and constants for the rsa modular exponentiation block
// used by rsa_modexp_ctrl, rsa_modexp_dp and rsa_modular_exponentiation_top
package rsa_modexp_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int DEF_MOD_WIDTH = 32;

   // configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MODULUS      = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PUBLIC_EXP   = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PRIVATE_EXP  = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DECRYPT_MODE = 2'd3;

   localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = 32'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXP,
      ST_MUL_ACC,
      ST_SHIFT,
      ST_MUL_SQR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;        // latch request and operands
      logic mul_start;   // clear partial product, load multiplier operand
      logic b_sel_base;  // multiplier operand: 0 accumulator, 1 base
      logic mul_step;    // one shift-add-reduce step
      logic acc_write;   // product goes to accumulator
      logic base_write;  // product goes to base
      logic e_shift;     // drop lowest exponent bit
      logic out_load;    // fill output register
   } dp_cmd_type;

   typedef struct packed {
      logic too_large;
      logic e_zero;
      logic e_lsb;
      logic e_rest_zero;
   } dp_status_type;

endpackage

// File: hdl/rsa_modular_exponentiation_top.sv
// top level of the rsa modular exponentiation block: configuration registers,
// controller and datapath; depends on rsa_modexp_pkg, rsa_modexp_ctrl, rsa_modexp_dp
//
// usage
// - csr channel (csr_valid/csr_ready, csr_index, csr_data) writes modulus,
//   public and private exponent and decrypt mode; csr_ready is always high;
//   the user makes writes while no request is in flight (not enforced)
// - req channel carries one message word; req_ready is high only while the
//   sequencer is idle, one request is worked on at a time
// - rsp channel returns message^exponent mod modulus and too_large; a message
//   not below the modulus gives result 0 with too_large set
// - from a request to rsp_valid: a rejected message or a zero exponent goes
//   straight to the output load; otherwise each exponent bit up to the
//   highest set one takes a decision and a shift state, a MOD_WIDTH-step
//   multiply when set and a MOD_WIDTH-step squaring unless last, then the
//   output load; req_ready returns only after the output load, so a new
//   request waits until the last one is through, all work being done by the
//   single shift-add multiplier (one bit per cycle)
// - the result sits in an output register; a new request is taken while it
//   waits, and a finished result holds in the datapath until rsp_ready frees
//   the output register
// - reset is synchronous, active high: registers return to modulus 1,
//   exponents 0, encrypt mode; any request in flight is dropped
module rsa_modular_exponentiation_top #(
   parameter int MOD_WIDTH = rsa_modexp_pkg::DEF_MOD_WIDTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [rsa_modexp_pkg::DATA_WIDTH-1:0]     req_message,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [rsa_modexp_pkg::DATA_WIDTH-1:0]     rsp_result,
   output logic                                      rsp_too_large,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [rsa_modexp_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [rsa_modexp_pkg::DATA_WIDTH-1:0]     csr_data
);

   logic [rsa_modexp_pkg::DATA_WIDTH-1:0] modulus_ff, public_exp_ff, private_exp_ff;
   logic                                  decrypt_mode_ff;

   rsa_modexp_pkg::dp_cmd_type    cmd;
   rsa_modexp_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff      <= rsa_modexp_pkg::MODULUS_RESET;
         public_exp_ff   <= '0;
         private_exp_ff  <= '0;
         decrypt_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rsa_modexp_pkg::REG_MODULUS:      modulus_ff      <= csr_data;
            rsa_modexp_pkg::REG_PUBLIC_EXP:   public_exp_ff   <= csr_data;
            rsa_modexp_pkg::REG_PRIVATE_EXP:  private_exp_ff  <= csr_data;
            rsa_modexp_pkg::REG_DECRYPT_MODE: decrypt_mode_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   rsa_modexp_ctrl #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rsa_modexp_dp #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_message      (req_message),
      .modulus          (modulus_ff),
      .public_exponent  (public_exp_ff),
      .private_exponent (private_exp_ff),
      .decrypt_mode     (decrypt_mode_ff),
      .rsp_result       (rsp_result),
      .rsp_too_large    (rsp_too_large)
   );

   // one request at a time: no new request right after one is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // a rejected message always reports a zero result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_large) |-> (rsp_result == '0))
      else $error("too_large result is not zero");

   // the output register is only refilled after a request finished its work
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !req_ready)
      else $error("output loaded while sequencer idle");

endmodule

// File: hdl/rsa_modexp_ctrl.sv
// sequencer for square-and-multiply: exponent bit loop and multiply step count
// depends on rsa_modexp_pkg
module rsa_modexp_ctrl #(
   parameter int MOD_WIDTH = rsa_modexp_pkg::DEF_MOD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  rsa_modexp_pkg::dp_status_type status,
   output rsa_modexp_pkg::dp_cmd_type    cmd
);

   localparam int CW = $clog2(MOD_WIDTH);
   localparam logic [CW-1:0] LAST_STEP = CW'(MOD_WIDTH - 1);

   rsa_modexp_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_modexp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rsa_modexp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rsa_modexp_pkg::ST_EXP;
            end
         end
         rsa_modexp_pkg::ST_EXP: begin
            if (status.too_large || status.e_zero) begin
               state_in = rsa_modexp_pkg::ST_DONE;
            end else if (status.e_lsb) begin
               cmd.mul_start  = 1'b1;
               cmd.b_sel_base = 1'b0;
               cnt_in         = '0;
               state_in       = rsa_modexp_pkg::ST_MUL_ACC;
            end else begin
               state_in = rsa_modexp_pkg::ST_SHIFT;
            end
         end
         rsa_modexp_pkg::ST_MUL_ACC: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cmd.acc_write = 1'b1;
               state_in      = rsa_modexp_pkg::ST_SHIFT;
            end
         end
         rsa_modexp_pkg::ST_SHIFT: begin
            cmd.e_shift = 1'b1;
            // no squaring once the remaining exponent is empty
            if (status.e_rest_zero) begin
               state_in = rsa_modexp_pkg::ST_DONE;
            end else begin
               cmd.mul_start  = 1'b1;
               cmd.b_sel_base = 1'b1;
               cnt_in         = '0;
               state_in       = rsa_modexp_pkg::ST_MUL_SQR;
            end
         end
         rsa_modexp_pkg::ST_MUL_SQR: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cmd.base_write = 1'b1;
               state_in       = rsa_modexp_pkg::ST_EXP;
            end
         end
         rsa_modexp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = rsa_modexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsa_modexp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/rsa_modexp_dp.sv
// datapath: operand registers, exponent shifter, shift-add modular multiplier
// and output register; depends on rsa_modexp_pkg
module rsa_modexp_dp #(
   parameter int MOD_WIDTH = rsa_modexp_pkg::DEF_MOD_WIDTH
) (
   input  logic                                   clock,
   input  rsa_modexp_pkg::dp_cmd_type             cmd,
   output rsa_modexp_pkg::dp_status_type          status,
   input  logic [rsa_modexp_pkg::DATA_WIDTH-1:0]  req_message,
   input  logic [rsa_modexp_pkg::DATA_WIDTH-1:0]  modulus,
   input  logic [rsa_modexp_pkg::DATA_WIDTH-1:0]  public_exponent,
   input  logic [rsa_modexp_pkg::DATA_WIDTH-1:0]  private_exponent,
   input  logic                                   decrypt_mode,
   output logic [rsa_modexp_pkg::DATA_WIDTH-1:0]  rsp_result,
   output logic                                   rsp_too_large
);

   localparam int W  = MOD_WIDTH;
   localparam int DW = rsa_modexp_pkg::DATA_WIDTH;

   logic [W+DW-1:0] msg_x, mod_x, exp_x;
   logic [W-1:0]    msg_w, mod_w, exp_w;

   logic [W-1:0] n_ff, e_ff, base_ff, acc_ff, r_ff, b_ff;
   logic         too_large_ff;
   logic [DW-1:0] result_ff;
   logic          result_too_large_ff;

   logic [W+1:0] sum, m1, m2, diff1, diff2;
   logic [W-1:0] r_next;
   logic [W+DW-1:0] acc_x;

   // fields are taken modulo 2^MOD_WIDTH, zero extended when wider
   assign msg_x = {{W{1'b0}}, req_message};
   assign mod_x = {{W{1'b0}}, modulus};
   assign exp_x = {{W{1'b0}}, (decrypt_mode ? private_exponent : public_exponent)};
   assign msg_w = msg_x[W-1:0];
   assign mod_w = mod_x[W-1:0];
   assign exp_w = exp_x[W-1:0];

   // r <- (2r + bit*base) mod n, sum stays below 3n
   assign sum   = {1'b0, r_ff, 1'b0} + {2'b00, (b_ff[W-1] ? base_ff : {W{1'b0}})};
   assign m1    = {2'b00, n_ff};
   assign m2    = {1'b0, n_ff, 1'b0};
   assign diff1 = sum - m1;
   assign diff2 = sum - m2;

   always_comb begin
      if (sum >= m2) begin
         r_next = diff2[W-1:0];
      end else if (sum >= m1) begin
         r_next = diff1[W-1:0];
      end else begin
         r_next = sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff         <= mod_w;
         e_ff         <= exp_w;
         base_ff      <= msg_w;
         acc_ff       <= W'(1);
         too_large_ff <= (msg_w >= mod_w);
      end
      if (cmd.mul_start) begin
         r_ff <= '0;
         b_ff <= cmd.b_sel_base ? base_ff : acc_ff;
      end
      if (cmd.mul_step) begin
         r_ff <= r_next;
         b_ff <= {b_ff[W-2:0], 1'b0};
      end
      if (cmd.acc_write) begin
         acc_ff <= r_next;
      end
      if (cmd.base_write) begin
         base_ff <= r_next;
      end
      if (cmd.e_shift) begin
         e_ff <= {1'b0, e_ff[W-1:1]};
      end
      if (cmd.out_load) begin
         result_ff           <= too_large_ff ? {DW{1'b0}} : acc_x[DW-1:0];
         result_too_large_ff <= too_large_ff;
      end
   end

   assign acc_x = {{DW{1'b0}}, acc_ff};

   assign status.too_large   = too_large_ff;
   assign status.e_zero      = (e_ff == '0);
   assign status.e_lsb       = e_ff[0];
   assign status.e_rest_zero = (e_ff[W-1:1] == '0);

   assign rsp_result    = result_ff;
   assign rsp_too_large = result_too_large_ff;

endmodule
